@@ hdl/crc16rfp_pkg.sv @@
// shared types, constants and the crc byte update for the response frame parser
// no dependencies; used by every other file in hdl
package crc16rfp_pkg;

    // field widths of the channels
    localparam int BYTE_W       = 8;
    localparam int PAYLOAD_BYTES = 6;
    localparam int PAYLOAD_W    = PAYLOAD_BYTES * BYTE_W;
    localparam int LEN_W        = 3;
    localparam int RUN_W        = 4;

    // defaults and fixed limits
    localparam int MAX_PAYLOAD_DEF = 6;
    localparam int CRC_ERROR_LIMIT = 10;
    localparam logic [RUN_W-1:0] RUN_SAT = '1;

    // crc-16/modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // commands with a known payload length
    localparam logic [BYTE_W-1:0] CMD_LEN6 = 8'd48;
    localparam logic [BYTE_W-1:0] CMD_LEN4 = 8'd69;
    localparam logic [BYTE_W-1:0] CMD_LEN5 = 8'd73;
    localparam logic [BYTE_W-1:0] CMD_LEN1 = 8'd95;
    localparam int EXCEPTION_BIT = 7;

    // payload lengths, compared against a 4-bit count
    localparam logic [3:0] LEN_SIX  = 4'd6;
    localparam logic [3:0] LEN_FOUR = 4'd4;
    localparam logic [3:0] LEN_FIVE = 4'd5;
    localparam logic [3:0] LEN_ONE  = 4'd1;

    // input item codes
    localparam logic ITEM_BYTE   = 1'b0;
    localparam logic ITEM_RESYNC = 1'b1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = '0;
    localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'd1;

    typedef enum logic [1:0] {
        STATUS_BUSY      = 2'd0,
        STATUS_DONE      = 2'd1,
        STATUS_CRC_ERR   = 2'd2,
        STATUS_EXCEPTION = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_ADDR   = 3'd0,
        ST_CMD    = 3'd1,
        ST_DATA   = 3'd2,
        ST_CRC_HI = 3'd3,
        ST_CRC_LO = 3'd4
    } hunt_state_t;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [BYTE_W-1:0]    command;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     payload_len;
        logic                 crc_limit_hit;
    } result_t;

    // one byte through the reflected crc, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/crc16rfp_in_if.sv @@
// valid/ready channel carrying one received byte or a resync
// depends on crc16rfp_pkg for the field widths
interface crc16rfp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [crc16rfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

@@ hdl/crc16rfp_out_if.sv @@
// valid/ready channel carrying one parser result
// depends on crc16rfp_pkg for the field widths
interface crc16rfp_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [crc16rfp_pkg::BYTE_W-1:0]     command;
    logic [crc16rfp_pkg::PAYLOAD_W-1:0]  payload;
    logic [crc16rfp_pkg::LEN_W-1:0]      payload_len;
    logic                                crc_limit_hit;

    modport source (output valid, output status, output command, output payload,
                    output payload_len, output crc_limit_hit, input ready);
    modport sink   (input valid, input status, input command, input payload,
                    input payload_len, input crc_limit_hit, output ready);
endinterface

@@ hdl/crc16_response_frame_parser.sv @@
// top level of the crc-16 framed response parser
// depends on crc16rfp_pkg, both channel interfaces and the crc16rfp_* modules
//
//   port      kind           carries
//   item      valid/ready    cmd (byte or resync), rx_byte
//   result    valid/ready    status, command, payload, payload_len, crc_limit_hit
//   apb       psel/penable   device_address at byte address 0
//
// one item per clock sustained while results are taken; an item waits in the input
// register and passes the frame logic into the result register when that register
// has room, and the result register then offers the item's result on the result channel
// the limit is the per-byte crc update and state step, done combinationally
// reset clears the frame state to address hunt, crc to 0xffff and both stages empty
// a stalled result holds in the output register while the input register still
// fills, so at most two items are in flight
module crc16_response_frame_parser #(
    parameter int MAX_PAYLOAD = crc16rfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    crc16rfp_in_if.sink                          item,
    crc16rfp_out_if.source                       result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crc16rfp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [crc16rfp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [crc16rfp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    logic [crc16rfp_pkg::BYTE_W-1:0] device_address;
    crc16rfp_pkg::item_t             in_item;
    crc16rfp_pkg::item_t             stage_item;
    logic                            stage_valid;
    logic                            take;
    logic                            advance;
    crc16rfp_pkg::result_t           core_result;
    crc16rfp_pkg::result_t           out_result;

    // item moves into the frame logic when the result register has room
    assign advance = stage_valid && take;

    assign in_item.cmd     = item.cmd;
    assign in_item.rx_byte = item.rx_byte;

    crc16rfp_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .device_address (device_address)
    );

    crc16rfp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item.valid),
        .in_ready    (item.ready),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    crc16rfp_frame_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .item           (stage_item),
        .device_address (device_address),
        .result         (core_result)
    );

    crc16rfp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .result     (core_result),
        .take       (take),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_result (out_result)
    );

    // result channel payload
    assign result.status        = out_result.status;
    assign result.command       = out_result.command;
    assign result.payload       = out_result.payload;
    assign result.payload_len   = out_result.payload_len;
    assign result.crc_limit_hit = out_result.crc_limit_hit;

endmodule

@@ hdl/crc16rfp_cfg.sv @@
// apb-style register port holding the device address
// depends on crc16rfp_pkg
module crc16rfp_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crc16rfp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [crc16rfp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [crc16rfp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic [crc16rfp_pkg::BYTE_W-1:0]      device_address
);

    logic [crc16rfp_pkg::BYTE_W-1:0]    device_address_reg;
    logic [crc16rfp_pkg::BYTE_W-1:0]    device_address_next;
    logic [crc16rfp_pkg::CFG_IDX_W-1:0] reg_index;
    logic                               wr_transfer;

    // word index, byte lanes ignored
    assign reg_index   = paddr[crc16rfp_pkg::CFG_ADDR_W-1:2];
    assign wr_transfer = psel & penable & pwrite;
    assign pready      = 1'b1;

    // register write
    always_comb
    begin
        device_address_next = device_address_reg;
        if (wr_transfer && reg_index == crc16rfp_pkg::REG_DEVICE_ADDRESS)
        begin
            device_address_next = pwdata[crc16rfp_pkg::BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= crc16rfp_pkg::DEVICE_ADDRESS_RESET;
        end
        else
        begin
            device_address_reg <= device_address_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (reg_index == crc16rfp_pkg::REG_DEVICE_ADDRESS)
        begin
            prdata = {{(crc16rfp_pkg::CFG_DATA_W - crc16rfp_pkg::BYTE_W){1'b0}},
                      device_address_reg};
        end
    end

    assign device_address = device_address_reg;

endmodule

@@ hdl/crc16rfp_in_stage.sv @@
// input register for one received item
// depends on crc16rfp_pkg
module crc16rfp_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  crc16rfp_pkg::item_t   in_item,
    input  logic                  advance,
    output logic                  stage_valid,
    output crc16rfp_pkg::item_t   stage_item
);

    logic                 valid_reg;
    logic                 valid_next;
    crc16rfp_pkg::item_t  item_reg;
    logic                 in_transfer;

    // free when empty or when the held item moves on this cycle
    assign in_ready    = !valid_reg || advance;
    assign in_transfer = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_transfer)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

@@ hdl/crc16rfp_frame_core.sv @@
// frame state machine, running crc, payload store and error run counter
// depends on crc16rfp_pkg; state moves once per advancing item
module crc16rfp_frame_core #(
    parameter int MAX_PAYLOAD = crc16rfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  crc16rfp_pkg::item_t               item,
    input  logic [crc16rfp_pkg::BYTE_W-1:0]   device_address,
    output crc16rfp_pkg::result_t             result
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    crc16rfp_pkg::hunt_state_t          state_reg, state_next;
    logic [crc16rfp_pkg::BYTE_W-1:0]    command_reg, command_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [15:0]                        crc_reg, crc_next;
    logic [crc16rfp_pkg::BYTE_W-1:0]    crc_hi_reg, crc_hi_next;
    logic [crc16rfp_pkg::RUN_W-1:0]     err_run_reg, err_run_next;
    logic [crc16rfp_pkg::BYTE_W-1:0]    payload_reg [MAX_PAYLOAD];

    logic [15:0]                        crc_base;
    logic [15:0]                        crc_upd;
    logic                               crc_match;
    logic                               is_byte;
    logic [CNT_W-1:0]                   count_inc;
    logic [3:0]                         count_ext;
    logic                               payload_full;
    logic                               store_wr;
    crc16rfp_pkg::status_t              status;
    logic [crc16rfp_pkg::PAYLOAD_W-1:0] packed_payload;

    // shared datapath
    assign is_byte   = (item.cmd == crc16rfp_pkg::ITEM_BYTE);
    assign crc_base  = (state_reg == crc16rfp_pkg::ST_ADDR) ? crc16rfp_pkg::CRC_INIT : crc_reg;
    assign crc_upd   = crc16rfp_pkg::crc_byte(crc_base, item.rx_byte);
    assign crc_match = ({crc_hi_reg, item.rx_byte} == crc_reg);
    assign count_inc = count_reg + CNT_W'(1);
    assign count_ext = 4'(count_inc);

    // payload length reached after this byte
    always_comb
    begin
        payload_full = 1'b0;
        if (count_inc >= CNT_W'(MAX_PAYLOAD))
        begin
            payload_full = 1'b1;
        end
        else if (command_reg[crc16rfp_pkg::EXCEPTION_BIT])
        begin
            payload_full = 1'b1;
        end
        else
        begin
            case (command_reg)
                crc16rfp_pkg::CMD_LEN6: payload_full = (count_ext >= crc16rfp_pkg::LEN_SIX);
                crc16rfp_pkg::CMD_LEN4: payload_full = (count_ext >= crc16rfp_pkg::LEN_FOUR);
                crc16rfp_pkg::CMD_LEN5: payload_full = (count_ext >= crc16rfp_pkg::LEN_FIVE);
                crc16rfp_pkg::CMD_LEN1: payload_full = (count_ext >= crc16rfp_pkg::LEN_ONE);
                default:                payload_full = 1'b0;
            endcase
        end
    end

    // frame status for this item
    always_comb
    begin
        status = crc16rfp_pkg::STATUS_BUSY;
        if (is_byte && state_reg == crc16rfp_pkg::ST_CRC_LO)
        begin
            if (!crc_match)
            begin
                status = crc16rfp_pkg::STATUS_CRC_ERR;
            end
            else if (command_reg[crc16rfp_pkg::EXCEPTION_BIT])
            begin
                status = crc16rfp_pkg::STATUS_EXCEPTION;
            end
            else
            begin
                status = crc16rfp_pkg::STATUS_DONE;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        command_next = command_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_hi_next  = crc_hi_reg;
        err_run_next = err_run_reg;
        store_wr     = 1'b0;
        if (!is_byte)
        begin
            state_next = crc16rfp_pkg::ST_ADDR;
        end
        else
        begin
            case (state_reg)
                crc16rfp_pkg::ST_ADDR:
                begin
                    if (item.rx_byte == device_address)
                    begin
                        crc_next   = crc_upd;
                        state_next = crc16rfp_pkg::ST_CMD;
                    end
                end
                crc16rfp_pkg::ST_CMD:
                begin
                    command_next = item.rx_byte;
                    crc_next     = crc_upd;
                    count_next   = '0;
                    state_next   = crc16rfp_pkg::ST_DATA;
                end
                crc16rfp_pkg::ST_DATA:
                begin
                    store_wr   = 1'b1;
                    count_next = count_inc;
                    crc_next   = crc_upd;
                    if (payload_full)
                    begin
                        state_next = crc16rfp_pkg::ST_CRC_HI;
                    end
                end
                crc16rfp_pkg::ST_CRC_HI:
                begin
                    crc_hi_next = item.rx_byte;
                    state_next  = crc16rfp_pkg::ST_CRC_LO;
                end
                crc16rfp_pkg::ST_CRC_LO:
                begin
                    if (status == crc16rfp_pkg::STATUS_CRC_ERR)
                    begin
                        if (err_run_reg != crc16rfp_pkg::RUN_SAT)
                        begin
                            err_run_next = err_run_reg + crc16rfp_pkg::RUN_W'(1);
                        end
                    end
                    else
                    begin
                        err_run_next = '0;
                    end
                    state_next = crc16rfp_pkg::ST_ADDR;
                end
                default:
                begin
                    state_next = crc16rfp_pkg::ST_ADDR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crc16rfp_pkg::ST_ADDR;
            command_reg <= '0;
            count_reg   <= '0;
            crc_reg     <= crc16rfp_pkg::CRC_INIT;
            crc_hi_reg  <= '0;
            err_run_reg <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_hi_reg  <= crc_hi_next;
            err_run_reg <= err_run_next;
        end
    end

    // payload store, written at the current byte count
    always_ff @(posedge clk)
    begin
        if (advance && store_wr)
        begin
            payload_reg[count_reg[IDX_W-1:0]] <= item.rx_byte;
        end
    end

    // left aligned payload, bytes past the count read as zero
    for (genvar i = 0; i < crc16rfp_pkg::PAYLOAD_BYTES; i++)
    begin : g_pack
        localparam int HI = crc16rfp_pkg::PAYLOAD_W - 1 - i * crc16rfp_pkg::BYTE_W;
        if (i < MAX_PAYLOAD)
        begin : g_used
            assign packed_payload[HI -: crc16rfp_pkg::BYTE_W] =
                (CNT_W'(i) < count_reg) ? payload_reg[i] : '0;
        end
        else
        begin : g_unused
            assign packed_payload[HI -: crc16rfp_pkg::BYTE_W] = '0;
        end
    end

    // result fields
    always_comb
    begin
        result               = '0;
        result.status        = status;
        result.crc_limit_hit = (err_run_next > crc16rfp_pkg::RUN_W'(crc16rfp_pkg::CRC_ERROR_LIMIT));
        if (status != crc16rfp_pkg::STATUS_BUSY)
        begin
            result.command     = command_reg;
            result.payload     = packed_payload;
            result.payload_len = crc16rfp_pkg::LEN_W'(count_reg);
        end
    end

endmodule

@@ hdl/crc16rfp_out_stage.sv @@
// result register towards the output channel
// depends on crc16rfp_pkg
module crc16rfp_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  crc16rfp_pkg::result_t   result,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output crc16rfp_pkg::result_t   out_result
);

    logic                   valid_reg;
    logic                   valid_next;
    crc16rfp_pkg::result_t  result_reg;

    // room when empty or when the held result is taken now
    assign take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
